>>> hw/rtl/windowed_altitude_percent_top_macros.svh
// Assertion macros for the windowed altitude percent block.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef WINDOWED_ALTITUDE_PERCENT_TOP_MACROS_SVH
`define WINDOWED_ALTITUDE_PERCENT_TOP_MACROS_SVH

// consequent checked in the same cycle
`define WAPT_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define WAPT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/wapt_pkg.sv
// Shared types and constants for the windowed altitude percent block.
// No dependencies; compiled first.
package wapt_pkg;

	localparam int SAMPLE_W   = 12;
	localparam int OUT_W      = 10;
	localparam int WINDOW_DEF = 20;
	localparam int CFG_IDX_W  = 2;
	localparam int STEP_W     = 6;

	localparam logic [SAMPLE_W-1:0] GROUND_RESET = 12'd0;
	localparam logic [SAMPLE_W-1:0] SPAN_RESET   = 12'd993;

	// span / 100 by reciprocal multiply, exact for 12-bit spans
	localparam int PCT_SCALE   = 100;
	localparam int RECIP_SHIFT = 19;
	localparam int RECIP_W     = 13;
	localparam int RECIP_MUL   = ((1 << RECIP_SHIFT) + PCT_SCALE - 1) / PCT_SCALE;

	localparam int OUT_MAX     = (1 << (OUT_W - 1)) - 1;
	localparam int OUT_MIN_MAG = 1 << (OUT_W - 1);

	localparam logic [CFG_IDX_W-1:0] CFG_GROUND = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SPAN   = 2'd1;

	typedef enum logic {
		ACTION_STORE  = 1'b0,
		ACTION_REPORT = 1'b1
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_AVG_GO,
		ST_AVG_WAIT,
		ST_PCT_GO,
		ST_PCT_WAIT,
		ST_DELIVER
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

>>> hw/rtl/wapt_stream_if.sv
// Channel interfaces: request, result and configuration write.
// Depends on wapt_pkg.
interface wapt_req_if;
	import wapt_pkg::*;
	logic                valid;
	logic                ready;
	logic                action;
	logic [SAMPLE_W-1:0] adc_sample;
	modport source (output valid, output action, output adc_sample, input ready);
	modport sink (input valid, input action, input adc_sample, output ready);
endinterface

interface wapt_rsp_if;
	import wapt_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] altitude_percent;
	modport source (output valid, output altitude_percent, input ready);
	modport sink (input valid, input altitude_percent, output ready);
endinterface

interface wapt_cfg_if;
	import wapt_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [SAMPLE_W-1:0]  data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/wapt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wapt_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 20
) (
	input  logic                                clk,
	input  logic                                we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                    wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                    rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> hw/rtl/wapt_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on wapt_pkg for the status struct.
module wapt_div #(
	parameter int NUM_W = 17,
	parameter int DEN_W = 6
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [NUM_W-1:0]            num,
	input  logic [DEN_W-1:0]            den,
	output logic [NUM_W-1:0]            quot,
	output wapt_pkg::div_stat_t         stat
);
	import wapt_pkg::*;

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0]   rem_sh;
	logic [DEN_W+1:0] diff;
	logic             fits;

	always_comb begin
		rem_sh = {rem_q, num_q[NUM_W-1]};
		diff   = {1'b0, rem_sh} - {2'b00, den_q};
		fits   = !diff[DEN_W+1];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// datapath; quotient bits shift in behind the dividend
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], fits};
			rem_q <= fits ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
		end
	end

	assign quot      = num_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;
endmodule

>>> hw/rtl/windowed_altitude_percent_top.sv
// Store: the block stays idle, so a new request is taken the next cycle.
// Report: after the transfer the ring is walked through the RAM read port and summed,
// then the serial divider makes two passes (average, then percent) before the result is registered.
// One request in flight; stores proceed while a result waits in the output register.
// Async reset clears control, ring valid bits (ring reads as zero) and write slot, and sets config to its reset values.
// Depends on wapt_pkg, the channel interfaces, wapt_ram, wapt_div and the macro header.
`include "windowed_altitude_percent_top_macros.svh"

module windowed_altitude_percent_top #(
	parameter int WINDOW = wapt_pkg::WINDOW_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	wapt_req_if.sink   req,
	wapt_rsp_if.source rsp,
	wapt_cfg_if.sink   cfg
);
	import wapt_pkg::*;

	localparam int ADDR_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int IDX_W    = $clog2(WINDOW + 1);
	localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW);
	localparam int DVS_W    = (IDX_W > STEP_W) ? IDX_W : STEP_W;
	localparam int PROD_W   = SAMPLE_W + RECIP_W;

	state_t state_q, state_d;

	logic [SAMPLE_W-1:0] ground_q;
	logic [SAMPLE_W-1:0] span_q;
	logic [ADDR_W-1:0]   write_slot_q;
	logic [WINDOW-1:0]   valid_q;
	logic [IDX_W-1:0]    idx_q;
	logic                rd_en_s1;
	logic                hit_s1;
	logic [SUM_W-1:0]    sum_q;
	logic                neg_q;
	logic [OUT_W-1:0]    pct_q;
	logic                rsp_valid_q;
	logic [OUT_W-1:0]    rsp_pct_q;

	logic                store_xfer;
	logic                report_xfer;
	logic                walk_rd;
	logic [SAMPLE_W-1:0] rd_data;
	logic                div_start;
	logic                load_rsp;
	logic [SUM_W-1:0]    div_num;
	logic [DVS_W-1:0]    div_den;
	logic [SUM_W-1:0]    div_quot;
	div_stat_t           div_st;

	logic [SAMPLE_W:0]   raised;
	logic [SAMPLE_W:0]   raised_mag;
	logic [PROD_W-1:0]   prod;
	logic [STEP_W-1:0]   step_raw;
	logic [STEP_W-1:0]   step;
	logic [OUT_W-1:0]    qm_lo;
	logic [OUT_W-1:0]    pct_d;

	assign req.ready   = (state_q == ST_IDLE);
	assign store_xfer  = req.valid && req.ready && (req.action == ACTION_STORE);
	assign report_xfer = req.valid && req.ready && (req.action == ACTION_REPORT);
	assign walk_rd     = (state_q == ST_SUM) && (idx_q < IDX_W'(WINDOW));

	assign cfg.ready            = 1'b1;
	assign rsp.valid            = rsp_valid_q;
	assign rsp.altitude_percent = $signed(rsp_pct_q);

	wapt_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (store_xfer),
		.waddr (write_slot_q),
		.wdata (req.adc_sample),
		.raddr (idx_q[ADDR_W-1:0]),
		.rdata (rd_data)
	);

	// ground - average, magnitude and sign, and the span / 100 step for the percent divide
	always_comb begin
		raised     = {1'b0, ground_q} - {1'b0, div_quot[SAMPLE_W-1:0]};
		raised_mag = raised[SAMPLE_W] ? (~raised + 1'b1) : raised;
		prod       = PROD_W'(span_q) * PROD_W'(RECIP_MUL);
		step_raw   = prod[RECIP_SHIFT +: STEP_W];
		step       = (step_raw == '0) ? STEP_W'(1) : step_raw;
	end

	always_comb begin
		if (state_q == ST_AVG_GO) begin
			div_num = sum_q;
			div_den = DVS_W'(WINDOW);
		end else begin
			div_num = SUM_W'(raised_mag[SAMPLE_W-1:0]);
			div_den = DVS_W'(step);
		end
	end

	wapt_div #(
		.NUM_W (SUM_W),
		.DEN_W (DVS_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.quot   (div_quot),
		.stat   (div_st)
	);

	// sign and clamp to the output range
	always_comb begin
		qm_lo = div_quot[OUT_W-1:0];
		if (neg_q) begin
			pct_d = (div_quot > SUM_W'(OUT_MIN_MAG)) ? OUT_W'(OUT_MIN_MAG) : (~qm_lo + 1'b1);
		end else begin
			pct_d = (div_quot > SUM_W'(OUT_MAX)) ? OUT_W'(OUT_MAX) : qm_lo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		load_rsp  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (report_xfer) begin
					state_d = ST_SUM;
				end
			end
			ST_SUM: begin
				// last read lands in sum_q at the edge leaving this state
				if (idx_q == IDX_W'(WINDOW)) begin
					state_d = ST_AVG_GO;
				end
			end
			ST_AVG_GO: begin
				div_start = 1'b1;
				state_d   = ST_AVG_WAIT;
			end
			ST_AVG_WAIT: begin
				if (div_st.done) begin
					state_d = ST_PCT_GO;
				end
			end
			ST_PCT_GO: begin
				div_start = 1'b1;
				state_d   = ST_PCT_WAIT;
			end
			ST_PCT_WAIT: begin
				if (div_st.done) begin
					state_d = ST_DELIVER;
				end
			end
			ST_DELIVER: begin
				if (!rsp_valid_q || rsp.ready) begin
					load_rsp = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ground_q     <= GROUND_RESET;
			span_q       <= SPAN_RESET;
			write_slot_q <= '0;
			valid_q      <= '0;
			rd_en_s1     <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					CFG_GROUND: ground_q <= cfg.data;
					CFG_SPAN:   span_q   <= cfg.data;
					default: ;
				endcase
			end
			if (store_xfer) begin
				valid_q[write_slot_q] <= 1'b1;
				write_slot_q <= (write_slot_q == ADDR_W'(WINDOW - 1)) ? '0 : write_slot_q + 1'b1;
			end
			rd_en_s1 <= walk_rd;
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (report_xfer) begin
			idx_q <= '0;
			sum_q <= '0;
		end else begin
			if (walk_rd) begin
				idx_q <= idx_q + 1'b1;
			end
			if (rd_en_s1 && hit_s1) begin
				sum_q <= sum_q + SUM_W'(rd_data);
			end
		end
		// unwritten slots read as zero
		hit_s1 <= valid_q[idx_q[ADDR_W-1:0]];
		if (state_q == ST_PCT_GO) begin
			neg_q <= raised[SAMPLE_W];
		end
		if (state_q == ST_PCT_WAIT && div_st.done) begin
			pct_q <= pct_d;
		end
		if (load_rsp) begin
			rsp_pct_q <= pct_q;
		end
	end

	`WAPT_ASSERT_NEXT(a_report_walks, report_xfer, state_q == ST_SUM, "report did not start ring walk")
	`WAPT_ASSERT_SAME(a_div_idle_at_start, div_start, !div_st.busy, "divider started while busy")
	`WAPT_ASSERT_SAME(a_slot_in_range, 1'b1, write_slot_q <= ADDR_W'(WINDOW - 1), "write slot out of range")
	`WAPT_ASSERT_NEXT(a_pct_to_deliver, state_q == ST_PCT_WAIT && div_st.done, state_q == ST_DELIVER, "result not staged after divide")
endmodule
